### hdl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants of the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

  typedef logic [15:0][31:0] words_t;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int STEPS_PER_DR  = 4;
  localparam int ROUND_STEPS   = DOUBLE_ROUNDS * STEPS_PER_DR;
  localparam int STEP_W        = $clog2(ROUND_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);

  localparam logic [2:0] CFG_KEY0     = 3'd0;
  localparam logic [2:0] CFG_KEY1     = 3'd1;
  localparam logic [2:0] CFG_KEY2     = 3'd2;
  localparam logic [2:0] CFG_KEY3     = 3'd3;
  localparam logic [2:0] CFG_NONCE_LO = 3'd4;
  localparam logic [2:0] CFG_NONCE_HI = 3'd5;
  localparam logic [2:0] CFG_INIT_CTR = 3'd6;

  localparam logic [3:0] FULL_COUNT = 4'd8;

endpackage

### hdl/cc20_round_unit.sv
// ----------------------------------------------------------------------------
// cc20_round_unit
// Half of a quarter round on four lanes at once, column or diagonal order.
// ----------------------------------------------------------------------------
module cc20_round_unit (
  input  cc20_pkg::words_t w_in,
  input  logic             diag,
  input  logic             second,
  output cc20_pkg::words_t w_out
);

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  always_comb begin
    logic [1:0]  li;
    logic [3:0]  ai, bi, ci, di;
    logic [31:0] a, b, c, d, x, y;
    w_out = w_in;
    for (int i = 0; i < 4; i++) begin
      li = 2'(i);
      ai = {2'b00, li};
      bi = {2'b01, li + (diag ? 2'd1 : 2'd0)};
      ci = {2'b10, li + (diag ? 2'd2 : 2'd0)};
      di = {2'b11, li + (diag ? 2'd3 : 2'd0)};
      a  = w_in[ai] + w_in[bi];
      x  = w_in[di] ^ a;
      d  = second ? rotl(x, 8) : rotl(x, 16);
      c  = w_in[ci] + d;
      y  = w_in[bi] ^ c;
      b  = second ? rotl(y, 7) : rotl(y, 12);
      w_out[ai] = a;
      w_out[bi] = b;
      w_out[ci] = c;
      w_out[di] = d;
    end
  end

endmodule

### hdl/cc20_block_core.sv
// ----------------------------------------------------------------------------
// cc20_block_core
// Keystream block sequencer: 40 round-unit steps, then the feed-forward add.
// ----------------------------------------------------------------------------
module cc20_block_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cc20_pkg::words_t init_words,
  output logic             done,
  output cc20_pkg::words_t ks_words
);

  typedef enum logic [1:0] {IDLE, ROUND, FINAL} state_t;

  state_t                       state;
  logic [cc20_pkg::STEP_W-1:0]  step;
  cc20_pkg::words_t             words;
  cc20_pkg::words_t             words_next;

  cc20_round_unit u_round (
    .w_in   (words),
    .diag   (step[1]),
    .second (step[0]),
    .w_out  (words_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            words <= init_words;
            step  <= '0;
            state <= ROUND;
          end
        end
        ROUND: begin
          words <= words_next;
          if (step == cc20_pkg::LAST_STEP) begin
            state <= FINAL;
          end else begin
            step <= step + 1'b1;
          end
        end
        FINAL: begin
          for (int i = 0; i < 16; i++) begin
            ks_words[i] <= words[i] + init_words[i];
          end
          done  <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == IDLE) else $error("block start while busy");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ROUND |-> step <= cc20_pkg::LAST_STEP) else $error("step overrun");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == FINAL && state == IDLE) else $error("stray done");

endmodule

### hdl/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 keystream XOR over 8-byte requests, one keystream block per
// eight non-empty requests.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    start_req, data_word, byte_count
//   out      output     out_valid / out_stall  result_word, result_count
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// A request that opens a keystream block waits in GEN for the 40-step loop
// through the shared round unit plus load and feed-forward; no new request is
// taken until the previous one has been written to the output register.
// Reset is synchronous; no clearing pass. A stalled result sits in the output
// register while the next request is taken and computed.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_word,
  output logic [3:0]  result_count,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [1:0] {IDLE, GEN, EMIT} state_t;

  state_t           state;
  logic [63:0]      key0, key1, key2, key3, nonce_lo;
  logic [31:0]      nonce_hi, init_ctr;
  logic [31:0]      blk_ctr, build_ctr;
  logic [2:0]       word_pos, item_pos;
  logic [63:0]      item_data;
  logic [3:0]       item_count;
  logic             core_start, core_done;
  cc20_pkg::words_t init_words, ks_words;

  logic        accept;
  logic [3:0]  cnt_sat;
  logic [31:0] ctr_eff;
  logic [2:0]  pos_eff;
  logic [63:0] ks, mask;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != IDLE);
  assign cnt_sat  = (byte_count > cc20_pkg::FULL_COUNT) ? cc20_pkg::FULL_COUNT : byte_count;
  assign ctr_eff  = start_req ? init_ctr : blk_ctr;
  assign pos_eff  = start_req ? 3'd0 : word_pos;
  assign ks       = {ks_words[{item_pos, 1'b1}], ks_words[{item_pos, 1'b0}]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < item_count) ? 8'hff : 8'h00;
    end
  end

  assign init_words = {nonce_hi, nonce_lo[63:32], nonce_lo[31:0], build_ctr,
                       key3[63:32], key3[31:0], key2[63:32], key2[31:0],
                       key1[63:32], key1[31:0], key0[63:32], key0[31:0],
                       cc20_pkg::SIGMA3, cc20_pkg::SIGMA2, cc20_pkg::SIGMA1,
                       cc20_pkg::SIGMA0};

  cc20_block_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (core_start),
    .init_words (init_words),
    .done       (core_done),
    .ks_words   (ks_words)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key0     <= '0;
      key1     <= '0;
      key2     <= '0;
      key3     <= '0;
      nonce_lo <= '0;
      nonce_hi <= '0;
      init_ctr <= 32'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cc20_pkg::CFG_KEY0:     key0     <= cfg_data;
        cc20_pkg::CFG_KEY1:     key1     <= cfg_data;
        cc20_pkg::CFG_KEY2:     key2     <= cfg_data;
        cc20_pkg::CFG_KEY3:     key3     <= cfg_data;
        cc20_pkg::CFG_NONCE_LO: nonce_lo <= cfg_data;
        cc20_pkg::CFG_NONCE_HI: nonce_hi <= cfg_data[31:0];
        cc20_pkg::CFG_INIT_CTR: init_ctr <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      blk_ctr    <= '0;
      word_pos   <= '0;
      core_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      core_start <= 1'b0;
      if (out_valid && !out_stall && state != EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            item_data  <= data_word;
            item_count <= cnt_sat;
            item_pos   <= pos_eff;
            if (cnt_sat == 4'd0) begin
              blk_ctr  <= ctr_eff;
              word_pos <= pos_eff;
              state    <= EMIT;
            end else if (pos_eff == 3'd0) begin
              build_ctr  <= ctr_eff;
              blk_ctr    <= ctr_eff + 32'd1;
              word_pos   <= 3'd1;
              core_start <= 1'b1;
              state      <= GEN;
            end else begin
              blk_ctr  <= ctr_eff;
              word_pos <= pos_eff + 3'd1;
              state    <= EMIT;
            end
          end
        end
        GEN: begin
          if (core_done) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!out_valid || !out_stall) begin
            result_word  <= (item_data ^ ks) & mask;
            result_count <= item_count;
            out_valid    <= 1'b1;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_done_in_gen: assert property (@(posedge clk) disable iff (rst)
    core_done |-> state == GEN) else $error("keystream done outside build");
  a_start_from_accept: assert property (@(posedge clk) disable iff (rst)
    core_start |-> $past(accept) && state == GEN) else $error("stray block start");
  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    accept && byte_count != 4'd0 |=> word_pos == $past(pos_eff) + 3'd1)
    else $error("word position did not advance");

endmodule
